// ===== sv/plf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types, letter constants and small helpers for the 5x5 digraph
// cipher block.
// ----------------------------------------------------------------------------
package plf_pkg;

  localparam int unsigned LetterW    = 5;
  localparam int unsigned NumLetters = 26;
  localparam int unsigned NumCells   = 25;
  localparam int unsigned SideLen    = 5;
  localparam int unsigned CoordW     = 3;

  localparam logic [LetterW-1:0] LETTER_A = 5'd0;
  localparam logic [LetterW-1:0] LETTER_I = 5'd8;
  localparam logic [LetterW-1:0] LETTER_J = 5'd9;
  localparam logic [LetterW-1:0] LETTER_X = 5'd23;
  localparam logic [LetterW-1:0] LETTER_Z = 5'd25;

  localparam logic [LetterW-1:0] CELLS_FULL = 5'(NumCells);
  localparam logic [LetterW-1:0] FILL_END   = 5'(NumLetters);

  // Row/column step: one to encipher, four (minus one mod 5) to decipher
  localparam logic [CoordW-1:0] STEP_ENC = 3'd1;
  localparam logic [CoordW-1:0] STEP_DEC = 3'd4;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_KEY   = 2'd1,
    FUNC_FILL  = 2'd2,
    FUNC_TEXT  = 2'd3
  } func_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input transfer this cycle
    logic fill_step; // place next alphabet letter during fill
    logic key_read;  // read the square at the pair's output cells
    logic out_sel;   // 0 shows first letter of pair, 1 the second
  } plf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_e func;       // decoded function of the offered item
    logic  pair_valid; // offered text item yields a pair
    logic  pair_twice; // the same pair is emitted twice
    logic  fill_done;  // fill sweep finished
  } plf_status_t;

  // i and j share one position entry
  function automatic logic [LetterW-1:0] fold_addr(input logic [LetterW-1:0] l);
    return (l > LETTER_I) ? l - 5'd1 : l;
  endfunction

  function automatic logic [LetterW-1:0] pad_for(input logic [LetterW-1:0] l);
    return (l == LETTER_X) ? LETTER_A : LETTER_X;
  endfunction

  function automatic logic [CoordW-1:0] cell_row(input logic [LetterW-1:0] p);
    logic [CoordW-1:0] r;
    if (p < 5'd5) r = 3'd0;
    else if (p < 5'd10) r = 3'd1;
    else if (p < 5'd15) r = 3'd2;
    else if (p < 5'd20) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

  function automatic logic [CoordW-1:0] cell_col(input logic [LetterW-1:0] p);
    logic [LetterW-1:0] base;
    logic [LetterW-1:0] diff;
    base = {2'b00, cell_row(p)} * 5'(SideLen);
    diff = p - base;
    return diff[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] wrap_step(input logic [CoordW-1:0] v,
                                                  input logic [CoordW-1:0] s);
    logic [CoordW:0] sum;
    sum = {1'b0, v} + {1'b0, s};
    if (sum >= 4'(SideLen)) sum = sum - 4'(SideLen);
    return sum[CoordW-1:0];
  endfunction

  function automatic logic [LetterW-1:0] cell_index(input logic [CoordW-1:0] r,
                                                    input logic [CoordW-1:0] c);
    logic [LetterW-1:0] idx;
    idx = {2'b00, r} * 5'(SideLen) + {2'b00, c};
    return (idx < CELLS_FULL) ? idx : 5'd0;
  endfunction

endpackage

// ===== sv/plf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_ctrl
// Sequencer: accepts items, runs the fill sweep, steps a pair through the
// square lookup and emits its two letters, once or twice.
// ----------------------------------------------------------------------------
module plf_ctrl
  import plf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_last_o,
  output plf_cmd_t    cmd_o,
  input  plf_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_KEY,
    S_EMIT0,
    S_EMIT1
  } state_e;

  state_e state_q, state_d;
  logic   repeat_q, repeat_d;
  logic   out_valid_q, out_valid_d;
  logic   out_sel_q, out_sel_d;
  logic   out_last_q, out_last_d;
  logic   accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;

  assign cmd_o.accept    = accept;
  assign cmd_o.fill_step = (state_q == S_FILL) && !status_i.fill_done;
  assign cmd_o.key_read  = (state_q == S_KEY);
  assign cmd_o.out_sel   = out_sel_q;

  // Next state and registered outputs
  always_comb begin
    state_d     = state_q;
    repeat_d    = repeat_q;
    out_valid_d = out_valid_q;
    out_sel_d   = out_sel_q;
    out_last_d  = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (status_i.func)
            FUNC_FILL: state_d = S_FILL;
            FUNC_TEXT: begin
              if (status_i.pair_valid) begin
                state_d  = S_KEY;
                repeat_d = status_i.pair_twice;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FILL: begin
        if (status_i.fill_done) state_d = S_IDLE;
      end
      S_KEY: begin
        state_d     = S_EMIT0;
        out_valid_d = 1'b1;
        out_sel_d   = 1'b0;
        out_last_d  = 1'b0;
      end
      S_EMIT0: begin
        if (!out_stall_i) begin
          state_d    = S_EMIT1;
          out_sel_d  = 1'b1;
          out_last_d = !repeat_q;
        end
      end
      S_EMIT1: begin
        if (!out_stall_i) begin
          if (repeat_q) begin
            // second copy of the same pair
            state_d    = S_EMIT0;
            repeat_d   = 1'b0;
            out_sel_d  = 1'b0;
            out_last_d = 1'b0;
          end else begin
            state_d     = S_IDLE;
            out_valid_d = 1'b0;
            out_last_d  = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      repeat_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_sel_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      repeat_q    <= repeat_d;
      out_valid_q <= out_valid_d;
      out_sel_q   <= out_sel_d;
      out_last_q  <= out_last_d;
    end
  end

endmodule

// ===== sv/plf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_datapath
// Key square and letter position stores, square building, text pairing
// and the row/column/rectangle lookup.
// ----------------------------------------------------------------------------
module plf_datapath
  import plf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [1:0]         func_i,
  input  logic [LetterW-1:0] letter_i,
  input  logic               last_i,
  input  plf_cmd_t           cmd_i,
  output plf_status_t        status_o,
  output logic [LetterW-1:0] out_letter_o
);

  // Stores: letter per cell, cell per letter (i and j folded)
  logic [LetterW-1:0] key_mem [NumCells];
  logic [LetterW-1:0] pos_mem [NumCells];

  logic                  mode_q;
  logic [NumLetters-1:0] used_q, used_d;
  logic [LetterW-1:0]    cells_q, cells_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [LetterW-1:0]    pend_letter_q, pend_letter_d;
  logic [LetterW-1:0]    fill_k_q, fill_k_d;

  logic [LetterW-1:0] pos_a_q, pos_b_q;
  logic               dec_q;
  logic [LetterW-1:0] key_a_q, key_b_q;

  func_e              func;
  logic               letter_ok;
  logic               pair_valid, pair_twice;
  logic [LetterW-1:0] pair_a, pair_b;
  logic               place_en;
  logic [LetterW-1:0] place_letter;
  logic               room;

  assign func      = func_e'(func_i);
  assign letter_ok = (letter_i <= LETTER_Z);
  assign room      = (cells_q < CELLS_FULL);

  assign status_o.func       = func;
  assign status_o.pair_valid = pair_valid;
  assign status_o.pair_twice = pair_twice;
  assign status_o.fill_done  = (fill_k_q == FILL_END) || !room;

  // Pair up text letters and update the held letter
  always_comb begin
    pair_valid    = 1'b0;
    pair_twice    = 1'b0;
    pair_a        = pend_letter_q;
    pair_b        = letter_i;
    pend_valid_d  = pend_valid_q;
    pend_letter_d = pend_letter_q;
    if (mode_q) begin
      if (letter_ok && pend_valid_q) begin
        pair_valid   = 1'b1;
        pend_valid_d = 1'b0;
      end else if (letter_ok) begin
        pend_valid_d  = !last_i;
        pend_letter_d = letter_i;
      end else if (last_i) begin
        pend_valid_d = 1'b0;
      end
    end else begin
      if (letter_ok && !pend_valid_q) begin
        if (last_i) begin
          pair_valid = 1'b1;
          pair_a     = letter_i;
          pair_b     = pad_for(letter_i);
        end else begin
          pend_valid_d  = 1'b1;
          pend_letter_d = letter_i;
        end
      end else if (letter_ok && (pend_letter_q != letter_i)) begin
        pair_valid   = 1'b1;
        pend_valid_d = 1'b0;
      end else if (letter_ok) begin
        // doubled letter: pad the held one, keep the new one held; on the last item emit the pair twice
        pair_valid   = 1'b1;
        pair_b       = pad_for(pend_letter_q);
        pair_twice   = last_i;
        pend_valid_d = !last_i;
      end else if (last_i && pend_valid_q) begin
        pair_valid   = 1'b1;
        pair_b       = pad_for(pend_letter_q);
        pend_valid_d = 1'b0;
      end
    end
    if (!pend_valid_d) pend_letter_d = LETTER_A;
  end

  // Choose a letter to place into the next free cell
  always_comb begin
    place_en     = 1'b0;
    place_letter = letter_i;
    if (cmd_i.fill_step) begin
      place_letter = fill_k_q;
      place_en     = room && !used_q[fill_k_q];
    end else if (cmd_i.accept && (func == FUNC_KEY)) begin
      place_en = letter_ok && room && !used_q[letter_i];
    end
  end

  // Next values of the square-building and fill-sweep state
  always_comb begin
    used_d   = used_q;
    cells_d  = cells_q;
    fill_k_d = fill_k_q;
    if (place_en) begin
      used_d[place_letter] = 1'b1;
      if ((place_letter == LETTER_I) || (place_letter == LETTER_J)) begin
        used_d[LETTER_I] = 1'b1;
        used_d[LETTER_J] = 1'b1;
      end
      cells_d = cells_q + 5'd1;
    end
    if (cmd_i.fill_step) fill_k_d = fill_k_q + 5'd1;
    if (cmd_i.accept) begin
      case (func)
        FUNC_CLEAR: begin
          used_d  = '0;
          cells_d = '0;
        end
        FUNC_FILL: fill_k_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 1'b0;
      used_q        <= '0;
      cells_q       <= '0;
      pend_valid_q  <= 1'b0;
      pend_letter_q <= '0;
      fill_k_q      <= '0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      used_q   <= used_d;
      cells_q  <= cells_d;
      fill_k_q <= fill_k_d;
      if (cmd_i.accept && (func == FUNC_CLEAR)) begin
        pend_valid_q  <= 1'b0;
        pend_letter_q <= '0;
      end else if (cmd_i.accept && (func == FUNC_TEXT)) begin
        pend_valid_q  <= pend_valid_d;
        pend_letter_q <= pend_letter_d;
      end
    end
  end

  // Write both stores when a letter is placed
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      key_mem[cells_q]                <= place_letter;
      pos_mem[fold_addr(place_letter)] <= cells_q;
    end
  end

  // Look up both positions on the text transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (func == FUNC_TEXT) && pair_valid) begin
      pos_a_q <= pos_mem[fold_addr(pair_a)];
      pos_b_q <= pos_mem[fold_addr(pair_b)];
      dec_q   <= mode_q;
    end
  end

  // Apply the same-row, same-column or rectangle rule
  logic [CoordW-1:0]  r0, c0, r1, c1, step;
  logic [LetterW-1:0] idx0, idx1;

  always_comb begin
    r0   = cell_row(pos_a_q);
    c0   = cell_col(pos_a_q);
    r1   = cell_row(pos_b_q);
    c1   = cell_col(pos_b_q);
    step = dec_q ? STEP_DEC : STEP_ENC;
    if (r0 == r1) begin
      idx0 = cell_index(r0, wrap_step(c0, step));
      idx1 = cell_index(r0, wrap_step(c1, step));
    end else if (c0 == c1) begin
      idx0 = cell_index(wrap_step(r0, step), c0);
      idx1 = cell_index(wrap_step(r1, step), c0);
    end else begin
      idx0 = cell_index(r0, c1);
      idx1 = cell_index(r1, c0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_read) begin
      key_a_q <= key_mem[idx0];
      key_b_q <= key_mem[idx1];
    end
  end

  assign out_letter_o = cmd_i.out_sel ? key_b_q : key_a_q;

endmodule

// ===== sv/playfair_digraph_cipher_top.sv =====
`timescale 1ns / 1ps
// Clear, key letter and unpaired text items leave the input open. A key end
// item sweeps one alphabet letter per cycle into the square until the
// alphabet ends or the square is full. A text item that completes a pair
// shows its first letter after a position read and then a square read; the
// input stays stalled until its letters are taken, also under output stalls.
// Reset clears fill state, held letter and mode; stores stay undefined.
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// 5x5 digraph cipher: builds the key square and enciphers or deciphers
// letter pairs.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_top
  import plf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [LetterW-1:0] letter_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LetterW-1:0] out_letter_o,
  output logic               out_last_o
);

  plf_cmd_t    cmd;
  plf_status_t status;

  plf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_last_o  (out_last_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  plf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .func_i       (func_i),
    .letter_i     (letter_i),
    .last_i       (last_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_letter_o (out_letter_o)
  );

endmodule

// ===== sv/plf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plf_checker
// Port-level checks on the cipher top: output/input exclusion, result
// bursts, clear completion and hold under stall.
// ----------------------------------------------------------------------------
module plf_checker
  import plf_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         func_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [LetterW-1:0] out_letter_o,
  input logic               out_last_o
);

  // No new item is taken while results are shown
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("result shown while input is open");

  // A result that is not the last one of its item is followed by another
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_last_o) |=> out_valid_o)
    else $error("result burst ended before its last result");

  // A clear item completes in its transfer cycle
  a_clear_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (func_i == FUNC_CLEAR)) |=> !in_stall_o)
    else $error("clear item did not complete in one cycle");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_letter_o) && $stable(out_last_o)))
    else $error("stalled result changed");

endmodule

bind playfair_digraph_cipher_top plf_checker u_plf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .func_i       (func_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_letter_o (out_letter_o),
  .out_last_o   (out_last_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 5x5 digraph cipher. Builds key squares, then
// streams text letters in both modes with bursty input and a stalling output
// side. Each result transfer is checked against a local model of the square
// and the held letter or a hand-worked row; a short table of such rows runs first.
// ----------------------------------------------------------------------------
module tb_top;
  import plf_pkg::*;

  localparam int HalfPeriod    = 10;
  localparam int ResetCycles   = 11;
  localparam int SettleCycles  = 40;   // longest fill sweep plus one pair
  localparam int IdleLimit     = 1000; // cycles without any transfer
  localparam int RandItems     = 430;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               last;
  } cipher_res_t;

  typedef struct {
    logic                    wr_mode;
    logic                    mode;
    func_e                   func;
    logic [LetterW-1:0]      letter;
    logic                    last;
    int                      n_typed; // -1 checks against the model
    logic [0:3][LetterW-1:0] typed;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_style_e;

  // DUT ports
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i      = FUNC_CLEAR;
  logic [LetterW-1:0] letter_i    = '0;
  logic               last_i      = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [LetterW-1:0] out_letter_o;
  logic               out_last_o;

  // Hand-worked results riding along with the item on the input side
  int                      row_typed_n = -1;
  logic [0:3][LetterW-1:0] row_typed   = '0;

  // Square model
  logic [LetterW-1:0] sq_letter [NumCells];
  logic [LetterW-1:0] sq_cell_of [NumLetters];
  logic [NumLetters-1:0] placed_set = '0;
  logic [LetterW-1:0] cells_used  = '0;
  logic               held_valid  = 1'b0;
  logic [LetterW-1:0] held_letter = '0;
  logic               decipher_on = 1'b0;
  logic [LetterW-1:0] pair_buf [4];
  int                 pair_cnt;

  cipher_res_t  cipher_letter_q [$];
  int unsigned  fail_cnt    = 0;
  int unsigned  idle_cycles = 0;

  stim_row_t    dir_rows [$];
  int           burst_left = 8;
  int           gap_left   = 0;
  int           n_sent     = 0;

  int unsigned  stall_tick  = 0;
  stall_style_e stall_style = STALL_NONE;

  playfair_digraph_cipher_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .letter_i     (letter_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_letter_o (out_letter_o),
    .out_last_o   (out_last_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Square and cipher model
  // --------------------------------------------------------------------------
  function automatic logic [LetterW-1:0] ltr(input byte ch);
    return LetterW'(ch - "a");
  endfunction

  function automatic void place_in_square(input logic [LetterW-1:0] l);
    sq_letter[cells_used] = l;
    sq_cell_of[l] = cells_used;
    placed_set[l] = 1'b1;
    // i and j live in one cell
    if (l == LETTER_I || l == LETTER_J) begin
      sq_cell_of[LETTER_I] = cells_used;
      sq_cell_of[LETTER_J] = cells_used;
      placed_set[LETTER_I] = 1'b1;
      placed_set[LETTER_J] = 1'b1;
    end
    cells_used = cells_used + 1'b1;
  endfunction

  function automatic logic [LetterW-1:0] square_at(input int r, input int c);
    int idx;
    idx = r * SideLen + c;
    return (idx < NumCells) ? sq_letter[idx] : LETTER_A;
  endfunction

  function automatic logic [LetterW-1:0] pad_letter(input logic [LetterW-1:0] l);
    return (l == LETTER_X) ? LETTER_A : LETTER_X;
  endfunction

  // Append the two letters of one enciphered or deciphered pair
  function automatic void cipher_two(input logic [LetterW-1:0] a,
                                     input logic [LetterW-1:0] b, input int step);
    int pa, pb, r0, c0, r1, c1;
    pa = int'(sq_cell_of[a]) % NumCells;
    pb = int'(sq_cell_of[b]) % NumCells;
    r0 = pa / SideLen;
    c0 = pa % SideLen;
    r1 = pb / SideLen;
    c1 = pb % SideLen;
    if (r0 == r1) begin
      pair_buf[pair_cnt]     = square_at(r0, (c0 + step) % SideLen);
      pair_buf[pair_cnt + 1] = square_at(r0, (c1 + step) % SideLen);
    end else if (c0 == c1) begin
      pair_buf[pair_cnt]     = square_at((r0 + step) % SideLen, c0);
      pair_buf[pair_cnt + 1] = square_at((r1 + step) % SideLen, c0);
    end else begin
      pair_buf[pair_cnt]     = square_at(r0, c1);
      pair_buf[pair_cnt + 1] = square_at(r1, c0);
    end
    pair_cnt += 2;
  endfunction

  function automatic void predict_item(input func_e f, input logic [LetterW-1:0] l,
                                       input logic lst);
    pair_cnt = 0;
    case (f)
      FUNC_CLEAR: begin
        placed_set  = '0;
        cells_used  = '0;
        held_valid  = 1'b0;
        held_letter = '0;
      end
      FUNC_KEY: begin
        if (l <= LETTER_Z && cells_used < CELLS_FULL && !placed_set[l])
          place_in_square(l);
      end
      FUNC_FILL: begin
        for (int k = 0; k < NumLetters; k++)
          if (cells_used < CELLS_FULL && !placed_set[k]) place_in_square(LetterW'(k));
      end
      default: begin
        if (decipher_on) begin
          // Pair strictly in order, drop a lone tail letter
          if (l <= LETTER_Z) begin
            if (held_valid) begin
              cipher_two(held_letter, l, int'(STEP_DEC));
              held_valid  = 1'b0;
              held_letter = '0;
            end else begin
              held_valid  = 1'b1;
              held_letter = l;
            end
          end
          if (lst) begin
            held_valid  = 1'b0;
            held_letter = '0;
          end
        end else begin
          if (l <= LETTER_Z) begin
            if (!held_valid) begin
              held_valid  = 1'b1;
              held_letter = l;
            end else if (held_letter != l) begin
              cipher_two(held_letter, l, int'(STEP_ENC));
              held_valid  = 1'b0;
              held_letter = '0;
            end else begin
              // Doubled letter: pad the held one, keep the new one
              cipher_two(held_letter, pad_letter(held_letter), int'(STEP_ENC));
            end
          end
          if (lst && held_valid) begin
            cipher_two(held_letter, pad_letter(held_letter), int'(STEP_ENC));
            held_valid  = 1'b0;
            held_letter = '0;
          end
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on input transfers, check output transfers
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    logic        moved;
    cipher_res_t want;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        predict_item(func_e'(func_i), letter_i, last_i);
        if (row_typed_n >= 0) begin
          for (int k = 0; k < row_typed_n; k++) begin
            want.letter = row_typed[k];
            want.last   = (k == row_typed_n - 1);
            cipher_letter_q.push_back(want);
          end
        end else begin
          for (int k = 0; k < pair_cnt; k++) begin
            want.letter = pair_buf[k];
            want.last   = (k == pair_cnt - 1);
            cipher_letter_q.push_back(want);
          end
        end
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (cipher_letter_q.size() == 0) begin
          $display("%0t: unexpected result, letter %0d last %0b", $time, out_letter_o,
                   out_last_o);
          fail_cnt++;
        end else begin
          want = cipher_letter_q.pop_front();
          if (out_letter_o !== want.letter) begin
            $display("%0t: out_letter expected %0d, got %0d", $time, want.letter,
                     out_letter_o);
            fail_cnt++;
          end
          if (out_last_o !== want.last) begin
            $display("%0t: out_last expected %0b, got %0b", $time, want.last, out_last_o);
            fail_cnt++;
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Abort when nothing moves for too long
  initial begin : watchdog
    wait (idle_cycles >= IdleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: stall on a pattern that changes to a randomly drawn style
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 255) stall_style <= stall_style_e'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
      default:     out_stall_i <= (stall_tick % 3 == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one item and hold it until the transfer; idle in bursts
  task automatic send_item(input func_e f, input logic [LetterW-1:0] l, input logic lst,
                           input int tn, input logic [0:3][LetterW-1:0] tl);
    if (gap_left > 0) begin
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    letter_i    <= l;
    last_i      <= lst;
    row_typed_n <= tn;
    row_typed   <= tl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!((f == FUNC_KEY || f == FUNC_TEXT) && l > LETTER_Z && !lst)) n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap_left > 0) in_valid_i <= 1'b0;
    end
  endtask

  // Drop valid, wait for every pending result, then let the block go idle
  task automatic drain_and_settle();
    if (gap_left == 0) in_valid_i <= 1'b0;
    gap_left = 0;
    @(posedge clk_i);
    while (cipher_letter_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    decipher_on = m;
  endtask

  function automatic void add_row(input logic wr, input logic m, input func_e f,
                                  input logic [LetterW-1:0] l, input logic lst,
                                  input int n, input logic [0:3][LetterW-1:0] tl);
    stim_row_t row;
    row.wr_mode = wr;
    row.mode    = m;
    row.func    = f;
    row.letter  = l;
    row.last    = lst;
    row.n_typed = n;
    row.typed   = tl;
    dir_rows.push_back(row);
  endfunction

  initial begin : stimulus
    int                 klen, tlen, roll, pick;
    logic [LetterW-1:0] l, prev, swap;
    logic               lst, have_prev;
    logic [LetterW-1:0] perm [NumLetters];

    for (int k = 0; k < NumCells; k++) sq_letter[k] = '0;
    for (int k = 0; k < NumLetters; k++) sq_cell_of[k] = '0;

    // Plain alphabetical square: abcde / fghik / lmnop / qrstu / vwxyz
    add_row(1, 0, FUNC_CLEAR, 5'd31, 1, 0, '0);
    add_row(0, 0, FUNC_FILL, LETTER_A, 0, 0, '0);
    add_row(0, 0, FUNC_TEXT, ltr("a"), 0, 0, '0);
    add_row(0, 0, FUNC_TEXT, ltr("b"), 0, 2, '{ltr("b"), ltr("c"), '0, '0});
    add_row(0, 0, FUNC_TEXT, ltr("v"), 0, 0, '0);
    add_row(0, 0, FUNC_TEXT, ltr("z"), 0, 2, '{ltr("w"), ltr("v"), '0, '0});
    // doubled x pads with a, then the held x flushes with a again
    add_row(0, 0, FUNC_TEXT, ltr("x"), 0, 0, '0);
    add_row(0, 0, FUNC_TEXT, ltr("x"), 1, 4, '{ltr("v"), ltr("c"), ltr("v"), ltr("c")});
    // i and j share a cell: same-row rule
    add_row(0, 0, FUNC_TEXT, ltr("i"), 0, 0, '0);
    add_row(0, 0, FUNC_TEXT, ltr("j"), 0, 2, '{ltr("k"), ltr("k"), '0, '0});
    // odd tail padded with x
    add_row(0, 0, FUNC_TEXT, ltr("z"), 1, 2, '{ltr("v"), ltr("y"), '0, '0});
    // out-of-range letter still flushes the held one
    add_row(0, 0, FUNC_TEXT, ltr("e"), 0, 0, '0);
    add_row(0, 0, FUNC_TEXT, 5'd30, 1, 2, '{ltr("c"), ltr("z"), '0, '0});
    // decipher, then a lone tail letter is dropped
    add_row(1, 1, FUNC_TEXT, ltr("w"), 0, 0, '0);
    add_row(0, 0, FUNC_TEXT, ltr("v"), 0, 2, '{ltr("v"), ltr("z"), '0, '0});
    add_row(0, 0, FUNC_TEXT, ltr("q"), 1, 0, '0);
    // held letter survives a mode change
    add_row(0, 0, FUNC_TEXT, ltr("c"), 0, 0, '0);
    add_row(1, 0, FUNC_TEXT, ltr("h"), 0, 2, '{ltr("h"), ltr("n"), '0, '0});
    // keyed square with j before i, a bad key letter, then fill
    add_row(0, 0, FUNC_CLEAR, LETTER_A, 0, 0, '0);
    add_row(0, 0, FUNC_KEY, LETTER_Z, 1, 0, '0);
    add_row(0, 0, FUNC_KEY, LETTER_J, 0, 0, '0);
    add_row(0, 0, FUNC_KEY, LETTER_I, 0, 0, '0);
    add_row(0, 0, FUNC_KEY, 5'd31, 0, 0, '0);
    add_row(0, 0, FUNC_FILL, 5'd31, 1, 0, '0);
    add_row(0, 0, FUNC_TEXT, ltr("i"), 0, -1, '0);
    add_row(0, 0, FUNC_TEXT, ltr("a"), 1, -1, '0);

    // Hold reset, then release on a clock edge
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].wr_mode) set_mode(dir_rows[r].mode);
      send_item(dir_rows[r].func, dir_rows[r].letter, dir_rows[r].last,
                dir_rows[r].n_typed, dir_rows[r].typed);
    end

    // Random sessions: usually rebuild a square, then stream a message
    n_sent = 0;
    while (n_sent < RandItems) begin
      if ($urandom_range(0, 3) == 0) set_mode($urandom_range(0, 1));
      if ($urandom_range(0, 9) != 0) begin
        send_item(FUNC_CLEAR, LetterW'($urandom_range(0, 31)), $urandom_range(0, 1), -1, '0);
        if ($urandom_range(0, 7) == 0) begin
          // Whole alphabet shuffled, then extra letters on a full square
          for (int k = 0; k < NumLetters; k++) perm[k] = LetterW'(k);
          for (int k = NumLetters - 1; k > 0; k--) begin
            pick       = $urandom_range(0, k);
            swap       = perm[k];
            perm[k]    = perm[pick];
            perm[pick] = swap;
          end
          for (int k = 0; k < NumLetters; k++)
            send_item(FUNC_KEY, perm[k], $urandom_range(0, 1), -1, '0);
          klen = 2;
        end else begin
          klen = $urandom_range(0, 8);
        end
        for (int k = 0; k < klen; k++) begin
          l = ($urandom_range(0, 19) == 0) ? LetterW'($urandom_range(26, 31))
                                          : LetterW'($urandom_range(0, 25));
          send_item(FUNC_KEY, l, $urandom_range(0, 1), -1, '0);
        end
        if ($urandom_range(0, 9) != 0)
          send_item(FUNC_FILL, LetterW'($urandom_range(0, 31)), $urandom_range(0, 1), -1, '0);
      end

      tlen      = $urandom_range(1, 24);
      have_prev = 1'b0;
      prev      = '0;
      for (int k = 0; k < tlen; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          l = LetterW'($urandom_range(26, 31));
        end else if (roll < 25 && have_prev) begin
          l = prev;
        end else if (roll < 35) begin
          case ($urandom_range(0, 2))
            0:       l = LETTER_I;
            1:       l = LETTER_J;
            default: l = LETTER_X;
          endcase
        end else begin
          l = LetterW'($urandom_range(0, 25));
        end
        lst = (k == tlen - 1) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 29) == 0);
        // Occasional stray control item inside a message
        if ($urandom_range(0, 39) == 0)
          send_item(func_e'($urandom_range(0, 2)), LetterW'($urandom_range(0, 31)),
                    $urandom_range(0, 1), -1, '0);
        send_item(FUNC_TEXT, l, lst, -1, '0);
        prev      = l;
        have_prev = 1'b1;
      end
    end

    drain_and_settle();
    if (fail_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/plf_pkg.sv
sv/plf_ctrl.sv
sv/plf_datapath.sv
sv/playfair_digraph_cipher_top.sv
sv/plf_checker.sv
tb/sv/tb_top.sv
